// ===== hw/rtl/ssh_pkg.sv =====
package ssh_pkg;

  // Store geometry
  localparam int BIN_COUNT   = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_W       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int EXT_W       = COUNT_WIDTH + 32;

  // Stream payload widths
  localparam int IN_DATA_W  = 40;   // sample_value, bin_index
  localparam int IN_USER_W  = 2;    // opcode
  localparam int OUT_DATA_W = 128;  // bin_count, square_diff_sum, counted_total

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOPE  = 3'd0,
    REG_OFFSET = 3'd1,
    REG_MASK   = 3'd2,
    REG_MASKEN = 3'd3,
    REG_BYTE   = 3'd4,
    REG_MEAN   = 3'd5
  } reg_idx_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_W-1:0]       bin_t;

endpackage

// ===== hw/rtl/ssh_ram.sv =====
module ssh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/scaled_sample_histogram.sv =====
// Channel   Direction  Transaction                     Payload
// s_*       in         one request (accum/read/clear)  tdata: sample, bin; tuser: opcode
// m_*       out        one read result                 tdata: count, square sum, total
// cfg_*     in         one register write              cfg_index, cfg_data
//
// One request per cycle while the pipeline does not stall. A read result passes
// through the four-stage pipeline (multiply, offset add + clamp, square + RAM read,
// read-modify-write) into the output register.
// Reset is synchronous; bin valid flags all clear together, no sweep of the RAM.
// The pipeline stalls only while a read sits in the last stage and the output
// register holds a result not yet taken; s_tready drops for those cycles.
module scaled_sample_histogram (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: [31:0] sample_value, [39:32] bin_index
  input  logic [ssh_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: [1:0] opcode
  input  logic [ssh_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata: [31:0] bin_count, [95:32] square_diff_sum, [127:96] counted_total
  output logic [ssh_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ssh_pkg::*;

  localparam count_t COUNT_MAX = '1;

  // Configuration registers
  logic signed [31:0] scale_slope;
  logic signed [31:0] scale_offset;
  logic signed [31:0] mask_value;
  logic               mask_enable;
  logic               byte_mode;
  logic signed [31:0] sample_mean;

  // Input fields
  logic signed [31:0] sample_value;
  logic [7:0]         bin_index;
  op_t                in_op;
  logic               masked;

  // Pipeline control
  logic stall;
  logic advance;

  // Stage 1: product, difference, byte-mode / read bin
  logic               s1_valid;
  op_t                s1_op;
  logic signed [63:0] s1_prod;
  logic signed [32:0] s1_diff;
  bin_t               s1_bin;
  logic               s1_oob;

  // Stage 2: final bin, deviation magnitude
  logic               s2_valid;
  op_t                s2_op;
  bin_t               s2_bin;
  logic               s2_oob;
  logic [31:0]        s2_mag;

  // Stage 3: square, RAM read issue
  logic               s3_valid;
  op_t                s3_op;
  bin_t               s3_bin;
  logic               s3_oob;
  logic [63:0]        s3_sq;

  // Stage 4: read-modify-write
  logic               s4_valid;
  op_t                s4_op;
  bin_t               s4_bin;
  logic               s4_oob;
  logic [63:0]        s4_sq;

  // Store state
  logic [BIN_COUNT-1:0] bin_valid;
  logic [63:0]          diff_square_acc;
  count_t               sample_tally;
  count_t               ram_rdata;
  logic                 ram_we;
  count_t               cur_count;
  count_t               new_count;

  // Write forwarding (write done at the edge this stage-4 item entered)
  logic   fwd_valid;
  bin_t   fwd_addr;
  count_t fwd_data;

  // Combinational helpers
  logic signed [63:0] prod;
  logic signed [63:0] scaled;
  logic [32:0]        diff_neg;
  logic [64:0]        acc_sum;

  // Output register
  logic [31:0] out_count;
  logic [63:0] out_sum;
  logic [31:0] out_total;

  function automatic bin_t clamp_bin(input logic signed [31:0] v);
    bin_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(32'(BIN_COUNT - 1))) begin
      r = BIN_W'(BIN_COUNT - 1);
    end else begin
      r = v[BIN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_out(input count_t c);
    logic [EXT_W-1:0] e;
    logic [31:0]      r;
    e = EXT_W'(c);
    if (e > EXT_W'(32'hFFFF_FFFF)) begin
      r = '1;
    end else begin
      r = e[31:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_slope  <= 32'sd65536;
      scale_offset <= '0;
      mask_value   <= '0;
      mask_enable  <= 1'b0;
      byte_mode    <= 1'b0;
      sample_mean  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLOPE:  scale_slope  <= $signed(cfg_data);
        REG_OFFSET: scale_offset <= $signed(cfg_data);
        REG_MASK:   mask_value   <= $signed(cfg_data);
        REG_MASKEN: mask_enable  <= cfg_data[0];
        REG_BYTE:   byte_mode    <= cfg_data[0];
        REG_MEAN:   sample_mean  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  assign sample_value = $signed(s_tdata[31:0]);
  assign bin_index    = s_tdata[39:32];
  assign in_op        = op_t'(s_tuser);
  assign masked       = mask_enable && (sample_value == mask_value);

  // Only a read waiting on a full, untaken output register holds the pipe.
  assign stall    = s4_valid && (s4_op == OP_READ) && m_tvalid && !m_tready;
  assign advance  = !stall;
  assign s_tready = advance;

  assign prod = sample_value * scale_slope;

  always_ff @(posedge clk) begin
    if (advance) begin
      // masked samples travel as bubbles
      s1_op   <= (in_op == OP_ACCUM && masked) ? OP_NOP : in_op;
      s1_prod <= prod;
      s1_diff <= {sample_value[31], sample_value} - {sample_mean[31], sample_mean};
      if (in_op == OP_READ) begin
        s1_bin <= BIN_W'(bin_index);
      end else begin
        s1_bin <= clamp_bin({{16{sample_value[31]}}, sample_value[31:16]});
      end
      s1_oob <= (32'(bin_index) >= 32'(BIN_COUNT));
    end
  end

  // ---------------------------------------------------------------- stage 2
  // floor((slope*sample + offset<<16) / 2^32) is bits [63:32] of the Q32.32 sum
  assign scaled   = s1_prod + {{16{scale_offset[31]}}, scale_offset, 16'b0};
  assign diff_neg = -s1_diff;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op  <= s1_op;
      s2_oob <= s1_oob;
      if (s1_op == OP_ACCUM && !byte_mode) begin
        s2_bin <= clamp_bin(scaled[63:32]);
      end else begin
        s2_bin <= s1_bin;
      end
      s2_mag <= s1_diff[32] ? diff_neg[31:0] : s1_diff[31:0];
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_op  <= s2_op;
      s3_bin <= s2_bin;
      s3_oob <= s2_oob;
      s3_sq  <= 64'(s2_mag) * 64'(s2_mag);
    end
  end

  ssh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BIN_COUNT),
    .AW    (BIN_W)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s4_bin),
    .wdata (new_count),
    .re    (advance),
    .raddr (s3_bin),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 4
  always_ff @(posedge clk) begin
    if (advance) begin
      s4_op  <= s3_op;
      s4_bin <= s3_bin;
      s4_oob <= s3_oob;
      s4_sq  <= s3_sq;
    end
  end

  // Newest value of the bin: last write, else RAM if the entry is live, else zero.
  always_comb begin
    if (fwd_valid && fwd_addr == s4_bin) begin
      cur_count = fwd_data;
    end else if (bin_valid[s4_bin]) begin
      cur_count = ram_rdata;
    end else begin
      cur_count = '0;
    end
  end

  assign new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
  assign ram_we    = advance && s4_valid && (s4_op == OP_ACCUM);
  assign acc_sum   = {1'b0, diff_square_acc} + {1'b0, s4_sq};

  // Pipeline valids, store state and forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      s4_valid        <= 1'b0;
      bin_valid       <= '0;
      diff_square_acc <= '0;
      sample_tally    <= '0;
      fwd_valid       <= 1'b0;
    end else if (advance) begin
      s1_valid  <= s_tvalid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      fwd_valid <= ram_we;
      if (s4_valid && s4_op == OP_CLEAR) begin
        bin_valid       <= '0;
        diff_square_acc <= '0;
        sample_tally    <= '0;
      end else if (ram_we) begin
        bin_valid[s4_bin] <= 1'b1;
        diff_square_acc   <= acc_sum[64] ? '1 : acc_sum[63:0];
        if (sample_tally != COUNT_MAX) begin
          sample_tally <= sample_tally + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_addr <= s4_bin;
      fwd_data <= new_count;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && s4_valid && s4_op == OP_READ) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s4_valid && s4_op == OP_READ) begin
      out_count <= s4_oob ? '0 : clamp_out(cur_count);
      out_sum   <= diff_square_acc;
      out_total <= clamp_out(sample_tally);
    end
  end

  assign m_tdata = {out_total, out_sum, out_count};

`ifndef SYNTH
  // A stalled read must never disturb the store.
  a_no_write_in_stall: assert property (@(posedge clk) disable iff (rst)
    stall |-> !ram_we)
    else $error("bin RAM written during stall");

  // A clear leaving the last stage empties every bin.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (advance && s4_valid && s4_op == OP_CLEAR) |=> (bin_valid == '0))
    else $error("bins still live after clear");

  // A forwarded write always belongs to a live entry.
  a_fwd_live: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> bin_valid[fwd_addr])
    else $error("forwarded write to a dead bin");

  // A read blocked at the output holds the input side.
  a_block_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && s4_valid && s4_op == OP_READ) |-> !s_tready)
    else $error("input taken while a read result is blocked");
`endif

endmodule
